// File: rtl/mzht_pkg.sv
// Shared types, codes and constants of the multi-zone hysteresis thermostat.
`default_nettype none

package mzht_pkg;

   // Table size and reset contents
   localparam int NUM_ZONES_DEFAULT = 8;
   localparam logic signed [7:0] SETPOINT_RESET = 8'sd24;
   localparam logic [7:0] DELTA_RESET = 8'd1;
   localparam logic [15:0] LOCKOUT_RESET = 16'd500;

   // Configuration port
   localparam int CSR_IDX_W = 1;
   localparam int CSR_DATA_W = 16;
   localparam logic [CSR_IDX_W-1:0] CSR_BLOCK_ENABLE = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_BUTTON_LOCKOUT = 1'd1;

   // Function codes of a request beat
   localparam logic [1:0] FUNC_WRITE = 2'd0;
   localparam logic [1:0] FUNC_TEMP = 2'd1;
   localparam logic [1:0] FUNC_BUTTON = 2'd2;

   // Result codes
   localparam logic [1:0] RC_HANDLED = 2'd0;
   localparam logic [1:0] RC_RANGE = 2'd1;
   localparam logic [1:0] RC_IGNORED = 2'd2;

   // Mode of a zone
   localparam logic MODE_HEAT = 1'b0;

   typedef struct packed {
      logic [1:0]        func;
      logic [2:0]        zone_index;
      logic signed [7:0] new_setpoint;
      logic [7:0]        new_delta;
      logic              new_mode;
      logic              new_status;
      logic              new_enabled;
      logic              new_has_relay;
      logic signed [7:0] measured_temp;
      logic              button_level;
      logic [31:0]       now_ms;
   } req_type;

   typedef struct packed {
      logic [2:0] result_zone;
      logic       relay_level;
      logic       zone_status;
      logic       zone_working;
      logic       relay_driven;
      logic [1:0] result_code;
   } rsp_type;

endpackage

`default_nettype wire

// File: rtl/multi_zone_hysteresis_thermostat.sv
// Top level: per-zone on/off thermostat table with hysteresis and button lockout.
`default_nettype none

// Takes one request beat per clock while the response drains, and returns one
// response beat for each. The zone table lives in flip-flops; the addressed zone
// is read, updated and written back in the cycle the beat is accepted, so the
// response appears in the cycle after acceptance and the next beat can follow at
// once. The response register is the only buffer: req_ready stays high while it
// is empty or being drained. That single register stage gives one beat per cycle
// while rsp_ready holds. CSR writes are expected only while no beat is in flight.
module multi_zone_hysteresis_thermostat #(
   parameter int NUM_ZONES = mzht_pkg::NUM_ZONES_DEFAULT
) (
   input  wire                                   clock,
   input  wire                                   reset,
   input  wire                                   req_valid,
   output logic                                  req_ready,
   input  wire mzht_pkg::req_type                req_data,
   output logic                                  rsp_valid,
   input  wire                                   rsp_ready,
   output mzht_pkg::rsp_type                     rsp_data,
   input  wire                                   csr_we,
   input  wire [mzht_pkg::CSR_IDX_W-1:0]         csr_index,
   input  wire [mzht_pkg::CSR_DATA_W-1:0]        csr_wdata
);

   localparam int IDX_W = (NUM_ZONES > 1) ? $clog2(NUM_ZONES) : 1;

   // Configuration registers
   logic        block_enable_ff;
   logic [15:0] lockout_ff;

   // Zone table
   logic signed [7:0] zone_setpoint_ff [NUM_ZONES];
   logic [7:0]        zone_delta_ff    [NUM_ZONES];
   logic              zone_mode_ff     [NUM_ZONES];
   logic              zone_status_ff   [NUM_ZONES];
   logic              zone_enable_ff   [NUM_ZONES];
   logic              zone_relay_ff    [NUM_ZONES];
   logic              zone_work_ff     [NUM_ZONES];
   logic              zone_level_ff    [NUM_ZONES];
   logic              zone_locked_ff   [NUM_ZONES];
   logic [31:0]       zone_start_ff    [NUM_ZONES];

   // Response register
   logic              rsp_valid_ff;
   mzht_pkg::rsp_type rsp_data_ff;
   mzht_pkg::rsp_type rsp_data_in;

   logic accept;
   logic in_range;
   logic [IDX_W+2:0] zone_wide;
   logic [IDX_W-1:0] idx;

   // Addressed zone, current values
   logic signed [7:0] cur_sp;
   logic [7:0]        cur_delta;
   logic              cur_mode;
   logic              cur_status;
   logic              cur_enable;
   logic              cur_relay;
   logic              cur_work;
   logic              cur_level;
   logic              cur_locked;
   logic [31:0]       cur_start;

   // Addressed zone, next values
   logic status_in;
   logic work_in;
   logic level_in;
   logic locked_in;
   logic driven_in;
   logic [1:0] code_in;

   logic signed [9:0] temp_ext;
   logic signed [9:0] sp_ext;
   logic signed [9:0] sp_hi;
   logic signed [9:0] sp_lo;
   logic [31:0]       elapsed;
   logic              lock_expired;

   assign accept    = req_valid && req_ready;
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Zone decode, widened so any table size compares correctly
   assign zone_wide = {{IDX_W{1'b0}}, req_data.zone_index};
   assign in_range  = (32'(zone_wide) < 32'(NUM_ZONES));
   assign idx       = zone_wide[IDX_W-1:0];

   // Table read
   assign cur_sp     = zone_setpoint_ff[idx];
   assign cur_delta  = zone_delta_ff[idx];
   assign cur_mode   = zone_mode_ff[idx];
   assign cur_status = zone_status_ff[idx];
   assign cur_enable = zone_enable_ff[idx];
   assign cur_relay  = zone_relay_ff[idx];
   assign cur_work   = zone_work_ff[idx];
   assign cur_level  = zone_level_ff[idx];
   assign cur_locked = zone_locked_ff[idx];
   assign cur_start  = zone_start_ff[idx];

   // Hysteresis thresholds and lockout timer
   assign temp_ext     = {{2{req_data.measured_temp[7]}}, req_data.measured_temp};
   assign sp_ext       = {{2{cur_sp[7]}}, cur_sp};
   assign sp_hi        = sp_ext + $signed({2'b00, cur_delta});
   assign sp_lo        = sp_ext - $signed({2'b00, cur_delta});
   assign elapsed      = req_data.now_ms - cur_start;
   assign lock_expired = (elapsed >= {16'd0, lockout_ff});

   // Per-item update of the addressed zone
   always_comb begin
      status_in = cur_status;
      work_in   = cur_work;
      level_in  = cur_level;
      locked_in = cur_locked;
      driven_in = 1'b0;
      code_in   = mzht_pkg::RC_HANDLED;
      case (req_data.func)
         mzht_pkg::FUNC_WRITE: begin
            status_in = req_data.new_status;
         end
         mzht_pkg::FUNC_TEMP: begin
            if (!block_enable_ff || !cur_enable || !cur_status || !cur_relay) begin
               code_in = mzht_pkg::RC_IGNORED;
            end else if (cur_mode == mzht_pkg::MODE_HEAT) begin
               if (!cur_work && (temp_ext < sp_ext)) begin
                  work_in = 1'b1; level_in = 1'b1; driven_in = 1'b1;
               end else if (cur_work && (temp_ext >= sp_hi)) begin
                  work_in = 1'b0; level_in = 1'b0; driven_in = 1'b1;
               end
            end else begin
               if (!cur_work && (temp_ext > sp_ext)) begin
                  work_in = 1'b1; level_in = 1'b1; driven_in = 1'b1;
               end else if (cur_work && (temp_ext <= sp_lo)) begin
                  work_in = 1'b0; level_in = 1'b0; driven_in = 1'b1;
               end
            end
         end
         mzht_pkg::FUNC_BUTTON: begin
            if (!block_enable_ff || !cur_enable) begin
               code_in = mzht_pkg::RC_IGNORED;
            end else if (!cur_locked) begin
               if (req_data.button_level) begin
                  status_in = !cur_status;
                  locked_in = 1'b1;
                  if (cur_relay) begin
                     level_in  = !cur_status;
                     driven_in = 1'b1;
                  end
               end
            end else if (lock_expired) begin
               locked_in = 1'b0;
            end
         end
         default: begin
            code_in = mzht_pkg::RC_IGNORED;
         end
      endcase
   end

   // Response payload
   always_comb begin
      rsp_data_in.result_zone = req_data.zone_index;
      if (in_range) begin
         rsp_data_in.relay_level  = level_in;
         rsp_data_in.zone_status  = status_in;
         rsp_data_in.zone_working = work_in;
         rsp_data_in.relay_driven = driven_in;
         rsp_data_in.result_code  = code_in;
      end else begin
         rsp_data_in.relay_level  = 1'b0;
         rsp_data_in.zone_status  = 1'b0;
         rsp_data_in.zone_working = 1'b0;
         rsp_data_in.relay_driven = 1'b0;
         rsp_data_in.result_code  = mzht_pkg::RC_RANGE;
      end
   end

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         block_enable_ff <= 1'b0;
         lockout_ff      <= mzht_pkg::LOCKOUT_RESET;
      end else if (csr_we) begin
         case (csr_index)
            mzht_pkg::CSR_BLOCK_ENABLE:   block_enable_ff <= csr_wdata[0];
            mzht_pkg::CSR_BUTTON_LOCKOUT: lockout_ff      <= csr_wdata[15:0];
            default: ;
         endcase
      end
   end

   // Zone table write-back
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_ZONES; i++) begin
            zone_setpoint_ff[i] <= mzht_pkg::SETPOINT_RESET;
            zone_delta_ff[i]    <= mzht_pkg::DELTA_RESET;
            zone_mode_ff[i]     <= mzht_pkg::MODE_HEAT;
            zone_status_ff[i]   <= 1'b0;
            zone_enable_ff[i]   <= 1'b0;
            zone_relay_ff[i]    <= 1'b0;
            zone_work_ff[i]     <= 1'b0;
            zone_level_ff[i]    <= 1'b0;
            zone_locked_ff[i]   <= 1'b0;
            zone_start_ff[i]    <= 32'd0;
         end
      end else if (accept && in_range) begin
         zone_status_ff[idx] <= status_in;
         zone_work_ff[idx]   <= work_in;
         zone_level_ff[idx]  <= level_in;
         zone_locked_ff[idx] <= locked_in;
         if (!cur_locked && locked_in) begin
            zone_start_ff[idx] <= req_data.now_ms;
         end
         if (req_data.func == mzht_pkg::FUNC_WRITE) begin
            zone_setpoint_ff[idx] <= req_data.new_setpoint;
            zone_delta_ff[idx]    <= req_data.new_delta;
            zone_mode_ff[idx]     <= req_data.new_mode;
            zone_enable_ff[idx]   <= req_data.new_enabled;
            zone_relay_ff[idx]    <= req_data.new_has_relay;
         end
      end
   end

   // Response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   // Every accepted beat shows up as a response on the next cycle
   a_accept_to_rsp: assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_valid)
      else $error("accepted beat produced no response");

   // A relay write is only reported for a handled item
   a_driven_handled: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.relay_driven) |-> (rsp_data.result_code == mzht_pkg::RC_HANDLED))
      else $error("relay driven on an ignored or rejected item");

   // Out-of-range zones report all flags low
   a_range_clear: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_data.result_code == mzht_pkg::RC_RANGE)) |->
         (!rsp_data.relay_level && !rsp_data.zone_status && !rsp_data.zone_working))
      else $error("out-of-range response carries zone flags");

   // A settings write lands in the table and is echoed in the response
   a_write_status: assert property (@(posedge clock) disable iff (reset)
      (accept && in_range && (req_data.func == mzht_pkg::FUNC_WRITE)) |=>
         (rsp_data.zone_status == $past(req_data.new_status)))
      else $error("settings write status not reflected");

endmodule

`default_nettype wire
